// ===== rtl/gtht_pkg.sv =====
// Shared types and constants for the grouped tag hash table.
package gtht_pkg;

	localparam int NUM_GROUPS_DEF      = 64;
	localparam int SLOTS_PER_GROUP_DEF = 16;
	localparam int KEY_BITS_DEF        = 64;
	localparam int VALUE_BITS_DEF      = 64;

	localparam int POS_BITS       = 5;
	localparam int HASH_GROUP_LSB = 7;
	localparam int LIMIT_BITS     = 11;
	localparam logic [LIMIT_BITS-1:0] LOAD_LIMIT_RST = 11'd819;

	localparam logic [7:0] TAG_EMPTY   = 8'h80;
	localparam logic [7:0] TAG_DELETED = 8'hFE;

	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] ST_NOT_FOUND = 3'd0;
	localparam logic [2:0] ST_FOUND     = 3'd1;
	localparam logic [2:0] ST_INSERTED  = 3'd2;
	localparam logic [2:0] ST_REMOVED   = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] hash_value;
		logic [63:0] key;
		logic [63:0] value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] value_out;
		logic [9:0]  slot_index;
	} out_item_t;

	typedef struct packed {
		logic                hit;
		logic [POS_BITS-1:0] hit_pos;
		logic                has_empty;
		logic [POS_BITS-1:0] empty_pos;
		logic                has_del;
		logic [POS_BITS-1:0] del_pos;
	} scan_t;

endpackage

// ===== rtl/gtht_group_scan.sv =====
// Compares one group's tags and keys; finds first hit, first empty, first deleted.
module gtht_group_scan #(
	parameter int SLOTS_PER_GROUP = gtht_pkg::SLOTS_PER_GROUP_DEF,
	parameter int KEY_BITS        = gtht_pkg::KEY_BITS_DEF
) (
	input  logic [SLOTS_PER_GROUP*8-1:0]        tag_row,
	input  logic [SLOTS_PER_GROUP*KEY_BITS-1:0] key_row,
	input  logic [6:0]                          tag,
	input  logic [KEY_BITS-1:0]                 key,
	output gtht_pkg::scan_t                     scan
);
	import gtht_pkg::*;

	always_comb begin
		scan = '0;
		for (int i = SLOTS_PER_GROUP - 1; i >= 0; i--) begin
			if (tag_row[i*8 +: 8] == {1'b0, tag} && key_row[i*KEY_BITS +: KEY_BITS] == key) begin
				scan.hit     = 1'b1;
				scan.hit_pos = POS_BITS'(i);
			end
			if (tag_row[i*8 +: 8] == TAG_EMPTY) begin
				scan.has_empty = 1'b1;
				scan.empty_pos = POS_BITS'(i);
			end
			if (tag_row[i*8 +: 8] == TAG_DELETED) begin
				scan.has_del = 1'b1;
				scan.del_pos = POS_BITS'(i);
			end
		end
	end

endmodule

// ===== rtl/grouped_tag_hash_table_core.sv =====
// Grouped tag hash table: top level with tag, key and value memories and the probe sequencer.
//
//  channel   signals                 direction  accepted when
//  request   start, request          in         start && !busy
//  result    done, result            out        done (one cycle, no stall)
//  config    cfg_we, cfg_wdata       in         cfg_we
//
// Each probed group is read through the single tag/key row read port in
// S_READ and checked in S_EVAL; a hit that returns a value adds S_VREAD and
// S_VOUT, and group selection first runs S_MOD when NUM_GROUPS is not a power of two.
// After reset the tag memory is swept to empty one group row at a time, busy high.
// Results cannot be stalled; busy covers the whole item.
module grouped_tag_hash_table_core #(
	parameter int NUM_GROUPS      = gtht_pkg::NUM_GROUPS_DEF,
	parameter int SLOTS_PER_GROUP = gtht_pkg::SLOTS_PER_GROUP_DEF,
	parameter int KEY_BITS        = gtht_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS      = gtht_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  gtht_pkg::in_item_t  request,
	output logic                done,
	output gtht_pkg::out_item_t result,
	input  logic                cfg_we,
	input  logic [10:0]         cfg_wdata
);
	import gtht_pkg::*;

	localparam int GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int TOTAL = NUM_GROUPS * SLOTS_PER_GROUP;
	localparam int SW = $clog2(TOTAL);
	localparam bit GROUP_POW2 = (NUM_GROUPS & (NUM_GROUPS - 1)) == 0;
	localparam int MOD_STEPS = 5;
	localparam int HB = 32 - HASH_GROUP_LSB;
	localparam logic [GW-1:0] LAST_GRP = GW'(NUM_GROUPS - 1);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MOD, S_READ, S_EVAL, S_VREAD, S_VOUT} state_t;

	state_t state_q;
	logic [1:0]            op_q;
	logic [6:0]            tag_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [GW-1:0]         grp_q, n_q, clr_q;
	logic [HB-1:0]         hb_q;
	logic [GW:0]           rem_q, rem_nx;
	logic [2:0]            mcnt_q;
	logic                  free_q, free_del_q;
	logic [GW-1:0]         free_grp_q;
	logic [POS_BITS-1:0]   free_pos_q;
	logic [SW-1:0]         hit_slot_q;
	logic [10:0]           live_q, del_q, limit_q;
	logic                  done_q;
	out_item_t             res_q;

	logic [SLOTS_PER_GROUP*8-1:0]        tag_mem [NUM_GROUPS];
	logic [SLOTS_PER_GROUP*KEY_BITS-1:0] key_mem [NUM_GROUPS];
	logic [VALUE_BITS-1:0]               val_mem [TOTAL];
	logic [SLOTS_PER_GROUP*8-1:0]        tag_rd_s1;
	logic [SLOTS_PER_GROUP*KEY_BITS-1:0] key_rd_s1;
	logic [VALUE_BITS-1:0]               val_rd_s1;

	scan_t sc;
	logic end_nf, room, free_any, ins_del, do_ins, do_rem, tag_we;
	logic [GW-1:0] ins_grp, tag_wgrp;
	logic [POS_BITS-1:0] ins_pos, tag_wpos;
	logic [7:0] tag_wdata;
	logic [SW-1:0] ins_slot, cur_hit_slot;

	function automatic logic [9:0] to_idx(input logic [SW-1:0] s);
		logic [SW+9:0] e;
		e = {10'd0, s};
		return e[9:0];
	endfunction

	function automatic logic [63:0] to_val(input logic [VALUE_BITS-1:0] v);
		logic [VALUE_BITS+63:0] e;
		e = {64'd0, v};
		return e[63:0];
	endfunction

	gtht_group_scan #(
		.SLOTS_PER_GROUP(SLOTS_PER_GROUP),
		.KEY_BITS(KEY_BITS)
	) u_scan (
		.tag_row(tag_rd_s1),
		.key_row(key_rd_s1),
		.tag(tag_q),
		.key(key_q),
		.scan(sc)
	);

	always_comb begin
		rem_nx = rem_q;
		for (int j = 0; j < MOD_STEPS; j++) begin
			rem_nx = {rem_nx[GW-1:0], hb_q[HB-1-j]};
			if (rem_nx >= (GW+1)'(NUM_GROUPS))
				rem_nx = rem_nx - (GW+1)'(NUM_GROUPS);
		end
	end

	always_comb begin
		end_nf   = !sc.hit && (sc.has_empty || n_q == LAST_GRP);
		room     = ({1'b0, live_q} + {1'b0, del_q}) < {1'b0, limit_q};
		free_any = free_q || sc.has_empty || sc.has_del;
		ins_grp  = free_q ? free_grp_q : grp_q;
		ins_pos  = free_q ? free_pos_q : (sc.has_empty ? sc.empty_pos : sc.del_pos);
		ins_del  = free_q ? free_del_q : !sc.has_empty;
		ins_slot = SW'(SW'(ins_grp) * SW'(SLOTS_PER_GROUP) + SW'(ins_pos));
		cur_hit_slot = SW'(SW'(grp_q) * SW'(SLOTS_PER_GROUP) + SW'(sc.hit_pos));
		do_ins = state_q == S_EVAL && end_nf && op_q == OP_INSERT && room && free_any;
		do_rem = state_q == S_EVAL && sc.hit && op_q == OP_REMOVE;
		tag_we    = do_ins || do_rem;
		tag_wgrp  = do_rem ? grp_q : ins_grp;
		tag_wpos  = do_rem ? sc.hit_pos : ins_pos;
		tag_wdata = do_rem ? TAG_DELETED : {1'b0, tag_q};
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR)
			tag_mem[clr_q] <= {SLOTS_PER_GROUP{TAG_EMPTY}};
		else if (tag_we)
			tag_mem[tag_wgrp][tag_wpos*8 +: 8] <= tag_wdata;
		tag_rd_s1 <= tag_mem[grp_q];
	end

	always_ff @(posedge clk) begin
		if (do_ins)
			key_mem[ins_grp][ins_pos*KEY_BITS +: KEY_BITS] <= key_q;
		key_rd_s1 <= key_mem[grp_q];
	end

	always_ff @(posedge clk) begin
		if (do_ins)
			val_mem[ins_slot] <= val_q;
		val_rd_s1 <= val_mem[hit_slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			op_q       <= '0;
			tag_q      <= '0;
			key_q      <= '0;
			val_q      <= '0;
			hb_q       <= '0;
			rem_q      <= '0;
			grp_q      <= '0;
			n_q        <= '0;
			mcnt_q     <= '0;
			free_q     <= 1'b0;
			free_grp_q <= '0;
			free_pos_q <= '0;
			free_del_q <= 1'b0;
			hit_slot_q <= '0;
			live_q     <= '0;
			del_q      <= '0;
			limit_q    <= LOAD_LIMIT_RST;
			done_q     <= 1'b0;
			res_q      <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we)
				limit_q <= cfg_wdata;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_GRP)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (start) begin
						op_q   <= request.operation;
						tag_q  <= request.hash_value[6:0];
						key_q  <= request.key[KEY_BITS-1:0];
						val_q  <= request.value[VALUE_BITS-1:0];
						hb_q   <= request.hash_value[31:HASH_GROUP_LSB];
						rem_q  <= '0;
						mcnt_q <= '0;
						n_q    <= '0;
						free_q <= 1'b0;
						grp_q  <= GW'(request.hash_value[31:HASH_GROUP_LSB] & HB'(NUM_GROUPS - 1));
						if (request.operation inside {OP_LOOKUP, OP_INSERT, OP_REMOVE}) begin
							state_q <= GROUP_POW2 ? S_READ : S_MOD;
						end else begin
							done_q <= 1'b1;
							res_q  <= '{status: ST_NOT_FOUND, value_out: '0, slot_index: '0};
						end
					end
				end
				S_MOD: begin
					rem_q  <= rem_nx;
					hb_q   <= hb_q << MOD_STEPS;
					mcnt_q <= mcnt_q + 1'b1;
					if (mcnt_q == 3'(HB / MOD_STEPS - 1)) begin
						grp_q   <= rem_nx[GW-1:0];
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_EVAL;
				S_EVAL: begin
					if (!free_q && (sc.has_empty || sc.has_del)) begin
						free_q     <= 1'b1;
						free_grp_q <= grp_q;
						free_pos_q <= sc.has_empty ? sc.empty_pos : sc.del_pos;
						free_del_q <= !sc.has_empty;
					end
					if (sc.hit) begin
						hit_slot_q <= cur_hit_slot;
						if (op_q == OP_REMOVE) begin
							if (live_q != '0)
								live_q <= live_q - 1'b1;
							del_q   <= del_q + 1'b1;
							done_q  <= 1'b1;
							res_q   <= '{status: ST_REMOVED, value_out: '0,
								slot_index: to_idx(cur_hit_slot)};
							state_q <= S_IDLE;
						end else begin
							state_q <= S_VREAD;
						end
					end else if (end_nf) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
						if (op_q != OP_INSERT)
							res_q <= '{status: ST_NOT_FOUND, value_out: '0, slot_index: '0};
						else if (do_ins) begin
							live_q <= live_q + 1'b1;
							if (ins_del && del_q != '0)
								del_q <= del_q - 1'b1;
							res_q <= '{status: ST_INSERTED, value_out: to_val(val_q),
								slot_index: to_idx(ins_slot)};
						end else
							res_q <= '{status: ST_FULL, value_out: '0, slot_index: '0};
					end else begin
						grp_q   <= (grp_q == LAST_GRP) ? '0 : grp_q + 1'b1;
						n_q     <= n_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_VREAD: state_q <= S_VOUT;
				S_VOUT: begin
					done_q  <= 1'b1;
					res_q   <= '{status: ST_FOUND, value_out: to_val(val_rd_s1),
						slot_index: to_idx(hit_slot_q)};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

	a_done_follows_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start)) else $error("result without an item");

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !done) else $error("result during clearing sweep");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_NOT_FOUND || result.status == ST_FULL)
			|-> result.slot_index == '0 && result.value_out == '0)
		else $error("miss or full carries data");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(do_ins && do_rem)) else $error("insert and remove in one cycle");

endmodule

// ===== sim/grouped_tag_hash_table_core_test.sv =====
// Self-checking testbench for the grouped tag hash table core: directed, random and load-limit phases.
`timescale 1ns / 1ps

module grouped_tag_hash_table_core_test;
	import gtht_pkg::*;

	localparam int GROUPS = 64;
	localparam int SLOTS = 16;
	localparam int TOTAL = GROUPS * SLOTS;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t request;
	logic done;
	out_item_t result;
	logic cfg_we;
	logic [10:0] cfg_wdata;

	grouped_tag_hash_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// table shadow
	logic [7:0] tags_m [TOTAL];
	logic [63:0] keys_m [TOTAL];
	logic [63:0] vals_m [TOTAL];
	int unsigned live_m;
	int unsigned dead_m;
	logic [10:0] limit_m;

	in_item_t pending_items[$];
	out_item_t expected_results[$];
	int idle_pct;
	int errors;
	int checked;
	int sent;
	int watchdog;
	bit timed_out;
	logic [63:0] known_keys[$];
	logic [31:0] known_hashes[$];

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic out_item_t apply_op(in_item_t it);
		out_item_t r;
		logic [7:0] tag;
		int g0, g, s, hit, pick;
		bit found, stop, dele;
		r = '0;
		tag = {1'b0, it.hash_value[6:0]};
		g0 = int'(it.hash_value[31:7] % GROUPS);
		found = 0;
		hit = 0;
		stop = 0;
		if (it.operation == OP_LOOKUP || it.operation == OP_INSERT
				|| it.operation == OP_REMOVE) begin
			g = g0;
			for (int n = 0; n < GROUPS && !stop; n++) begin
				for (int p = 0; p < SLOTS && !found; p++) begin
					s = g * SLOTS + p;
					if (tags_m[s] == tag && keys_m[s] == it.key) begin
						found = 1;
						hit = s;
					end
				end
				for (int p = 0; p < SLOTS; p++)
					if (tags_m[g * SLOTS + p] == TAG_EMPTY) stop = 1;
				if (found) stop = 1;
				g = (g + 1) % GROUPS;
			end
		end
		if (it.operation == OP_LOOKUP || it.operation == OP_INSERT) begin
			if (found) begin
				r.status = ST_FOUND;
				r.value_out = vals_m[hit];
				r.slot_index = hit[9:0];
			end else if (it.operation == OP_INSERT) begin
				r.status = ST_FULL;
				if (live_m + dead_m < limit_m) begin
					g = g0;
					for (int n = 0; n < GROUPS && r.status == ST_FULL; n++) begin
						pick = -1;
						dele = 0;
						for (int p = SLOTS - 1; p >= 0; p--)
							if (tags_m[g * SLOTS + p] == TAG_EMPTY) pick = p;
						if (pick < 0) begin
							for (int p = SLOTS - 1; p >= 0; p--)
								if (tags_m[g * SLOTS + p] == TAG_DELETED) pick = p;
							dele = pick >= 0;
						end
						if (pick >= 0) begin
							s = g * SLOTS + pick;
							tags_m[s] = tag;
							keys_m[s] = it.key;
							vals_m[s] = it.value;
							live_m++;
							if (dele && dead_m > 0) dead_m--;
							r.status = ST_INSERTED;
							r.value_out = it.value;
							r.slot_index = s[9:0];
						end
						g = (g + 1) % GROUPS;
					end
				end
			end
		end else if (it.operation == OP_REMOVE && found) begin
			tags_m[hit] = TAG_DELETED;
			if (live_m > 0) live_m--;
			dead_m++;
			r.status = ST_REMOVED;
			r.slot_index = hit[9:0];
		end
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 0;
			request <= '0;
		end else if (start && !busy) begin
			expected_results.push_back(apply_op(request));
			sent++;
			if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
				request <= pending_items.pop_front();
			end else begin
				start <= 0;
			end
		end else if (!start && pending_items.size() != 0
				&& $urandom_range(99) >= idle_pct) begin
			start <= 1;
			request <= pending_items.pop_front();
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				errors++;
			end else begin
				out_item_t e;
				e = expected_results.pop_front();
				checked++;
				if (e.status !== result.status)
					$display("%0t: status expected %0d actual %0d", $time,
						e.status, result.status);
				if (e.value_out !== result.value_out)
					$display("%0t: value_out expected %h actual %h", $time,
						e.value_out, result.value_out);
				if (e.slot_index !== result.slot_index)
					$display("%0t: slot_index expected %0d actual %0d", $time,
						e.slot_index, result.slot_index);
				if (e !== result) errors++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) watchdog <= 0;
		else watchdog <= watchdog + 1;
		if (watchdog >= WATCHDOG_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic in_item_t make_item(logic [1:0] op, logic [31:0] h,
			logic [63:0] k, logic [63:0] v);
		in_item_t it;
		it.operation = op;
		it.hash_value = h;
		it.key = k;
		it.value = v;
		return it;
	endfunction

	function automatic in_item_t random_item(int grp_span);
		in_item_t it;
		int pick;
		logic [31:0] h;
		h = $urandom;
		h[31:7] = (h[31:7] & ~25'h3F) | 25'($urandom_range(grp_span - 1));
		it = make_item(2'($urandom_range(2)), h, {$urandom, $urandom}, {$urandom, $urandom});
		if (known_keys.size() != 0 && $urandom_range(99) < 60) begin
			pick = $urandom_range(known_keys.size() - 1);
			it.key = known_keys[pick];
			it.hash_value = known_hashes[pick];
		end else if (it.operation == OP_INSERT) begin
			known_keys.push_back(it.key);
			known_hashes.push_back(it.hash_value);
		end
		if ($urandom_range(99) < 2) it.operation = OP_UNUSED;
		return it;
	endfunction

	task automatic drain();
		while (pending_items.size() != 0 || start || busy || expected_results.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_limit(logic [10:0] lim);
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= lim;
		limit_m = lim;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		idle_pct = 0;
		errors = 0;
		checked = 0;
		sent = 0;
		watchdog = 0;
		live_m = 0;
		dead_m = 0;
		limit_m = LOAD_LIMIT_RST;
		for (int i = 0; i < TOTAL; i++) begin
			tags_m[i] = TAG_EMPTY;
			keys_m[i] = '0;
			vals_m[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, every op, present-key insert, absent remove, unused op
		pending_items.push_back(make_item(OP_LOOKUP, 32'h0, 64'h0, 64'h0));
		pending_items.push_back(make_item(OP_INSERT, 32'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF));
		pending_items.push_back(make_item(OP_INSERT, 32'hFFFF_FFFF, '1, '1));
		pending_items.push_back(make_item(OP_INSERT, 32'hFFFF_FFFF, '1, 64'h5));
		pending_items.push_back(make_item(OP_LOOKUP, 32'hFFFF_FFFF, '1, 64'h0));
		pending_items.push_back(make_item(OP_LOOKUP, 32'h0, 64'h0, '1));
		pending_items.push_back(make_item(OP_REMOVE, 32'h0, 64'h1, 64'h0));
		pending_items.push_back(make_item(OP_REMOVE, 32'h0, 64'h0, 64'h0));
		pending_items.push_back(make_item(OP_LOOKUP, 32'h0, 64'h0, 64'h0));
		pending_items.push_back(make_item(OP_INSERT, 32'h55, 64'hAAAA_5555_AAAA_5555,
			64'h5555_AAAA_5555_AAAA));
		pending_items.push_back(make_item(OP_UNUSED, 32'hFFFF_FFFF, '1, '1));
		for (int i = 0; i < 20; i++)
			pending_items.push_back(make_item(OP_INSERT, 32'h80 | i, 64'(i + 100), 64'(i)));
		for (int i = 0; i < 4; i++)
			pending_items.push_back(make_item(OP_REMOVE, 32'h80 | i, 64'(i + 100), 64'h0));
		pending_items.push_back(make_item(OP_INSERT, 32'h80, 64'h999, 64'h1));
		drain();

		// random phases with varying sender idling
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 86 : (ph == 2) ? 12 : 0;
			for (int i = 0; i < 170; i++) pending_items.push_back(random_item(ph == 3 ? 64 : 4));
			drain();
		end

		// load limit extremes
		set_limit(11'd1);
		for (int i = 0; i < 20; i++) pending_items.push_back(random_item(64));
		drain();
		set_limit(11'd0);
		for (int i = 0; i < 20; i++) pending_items.push_back(random_item(64));
		drain();
		set_limit(11'd1024);
		idle_pct = 0;
		for (int i = 0; i < 80; i++)
			pending_items.push_back(make_item(OP_INSERT, {$urandom} & 32'hFFFF_FC7F,
				{$urandom, $urandom}, {$urandom, $urandom}));
		for (int i = 0; i < 60; i++) pending_items.push_back(random_item(64));
		drain();
		set_limit(11'd2047);
		for (int i = 0; i < 100; i++) pending_items.push_back(random_item(64));
		drain();
		set_limit(LOAD_LIMIT_RST);
		for (int i = 0; i < 50; i++) pending_items.push_back(random_item(8));
		drain();

		$display("ran %0d items, checked %0d results; limits 0, 1, 819, 1024, 2047 covered",
			sent, checked);
		$display("final occupancy: %0d live, %0d deleted", live_m, dead_m);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
